// ----- rtl/rfo_pkg.sv -----
// ----------------------------------------------------------------------------
// rfo_pkg
// shared widths, operation codes and defaults of the overwrite-oldest ring fifo
// ----------------------------------------------------------------------------
package rfo_pkg;

	localparam int SLOTS_DEF      = 16;
	localparam int ITEM_WIDTH_DEF = 32;

	localparam int FUNC_W   = 2;
	localparam int DATA_W   = 32;
	localparam int OFFSET_W = 5;
	localparam int COUNT_W  = 4;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [DATA_W-1:0]   data_t;
	typedef logic [OFFSET_W-1:0] offset_t;
	typedef logic [COUNT_W-1:0]  count_t;

	localparam func_t OP_ENQ  = 2'd0;
	localparam func_t OP_DEQ  = 2'd1;
	localparam func_t OP_PEEK = 2'd2;
	localparam func_t OP_CLR  = 2'd3;

endpackage

// ----- rtl/rfo_req_if.sv -----
// ----------------------------------------------------------------------------
// rfo_req_if
// request channel: operation code, item and peek offset
// ----------------------------------------------------------------------------
interface rfo_req_if;

	logic             valid;
	logic             ready;
	rfo_pkg::func_t   func;
	rfo_pkg::data_t   data_in;
	rfo_pkg::offset_t offset;

	modport source (output valid, output func, output data_in, output offset, input ready);
	modport sink   (input valid, input func, input data_in, input offset, output ready);

endinterface

// ----- rtl/rfo_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rfo_rsp_if
// response channel: status, item read and occupancy flags
// ----------------------------------------------------------------------------
interface rfo_rsp_if;

	logic            valid;
	logic            ready;
	logic            ok;
	rfo_pkg::data_t  data_out;
	rfo_pkg::count_t count;
	logic            is_empty;
	logic            is_full;

	modport source (output valid, output ok, output data_out, output count,
		output is_empty, output is_full, input ready);
	modport sink   (input valid, input ok, input data_out, input count,
		input is_empty, input is_full, output ready);

endinterface

// ----- rtl/rfo_store.sv -----
// ----------------------------------------------------------------------------
// rfo_store
// item memory, one write and one registered read port, zeroed by a sweep
// after reset
// ----------------------------------------------------------------------------
module rfo_store #(
	parameter int SLOTS      = rfo_pkg::SLOTS_DEF,
	parameter int ITEM_WIDTH = rfo_pkg::ITEM_WIDTH_DEF,
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [IDX_W-1:0]      waddr,
	input  logic [ITEM_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [IDX_W-1:0]      raddr,
	output logic [ITEM_WIDTH-1:0] rdata,
	output logic                  init_done
);

	logic [ITEM_WIDTH-1:0] mem [SLOTS];
	logic [IDX_W-1:0]      clr_idx_q;
	logic                  clr_busy_q;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [ITEM_WIDTH-1:0] mem_wdata;

	// zeroing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign mem_we    = clr_busy_q | we;
	assign mem_waddr = clr_busy_q ? clr_idx_q : waddr;
	assign mem_wdata = clr_busy_q ? '0 : wdata;
	assign init_done = ~clr_busy_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/rfo_ctrl.sv -----
// ----------------------------------------------------------------------------
// rfo_ctrl
// head and tail pointers, operation decode, memory access and response stages
// ----------------------------------------------------------------------------
module rfo_ctrl #(
	parameter int SLOTS      = rfo_pkg::SLOTS_DEF,
	parameter int ITEM_WIDTH = rfo_pkg::ITEM_WIDTH_DEF,
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rfo_req_if.sink               req,
	rfo_rsp_if.source             rsp,
	output logic                  we,
	output logic [IDX_W-1:0]      waddr,
	output logic [ITEM_WIDTH-1:0] wdata,
	output logic                  re,
	output logic [IDX_W-1:0]      raddr,
	input  logic [ITEM_WIDTH-1:0] rdata,
	input  logic                  init_done
);

	localparam int SUM_W = ((IDX_W > rfo_pkg::OFFSET_W) ? IDX_W : rfo_pkg::OFFSET_W) + 1;
	localparam int CNT_W = (IDX_W > rfo_pkg::COUNT_W) ? IDX_W : rfo_pkg::COUNT_W;

	function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(SLOTS - 1)) ? '0 : i + 1'b1;
	endfunction

	logic [IDX_W-1:0] head_q, tail_q, head_n, tail_n;
	logic             accept, adv_s1;
	logic             ok_n, sel_n;
	logic             full_cur, empty_cur;
	logic [SUM_W-1:0] peek_sum, peek_idx;
	logic             peek_ok;
	logic [IDX_W:0]   diff;
	logic [CNT_W-1:0] cnt_ext;

	logic                     v_s1, ok_s1, sel_s1, empty_s1, full_s1;
	logic [rfo_pkg::COUNT_W-1:0] count_s1;
	logic                     ov_q;

	assign full_cur  = (wrap_next(tail_q) == head_q);
	assign empty_cur = (head_q == tail_q);

	assign peek_sum = SUM_W'(head_q) + SUM_W'(req.offset);
	assign peek_idx = (peek_sum >= SUM_W'(SLOTS)) ? peek_sum - SUM_W'(SLOTS) : peek_sum;
	assign peek_ok  = (SUM_W'(req.offset) <= SUM_W'(SLOTS));

	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		ok_n   = 1'b1;
		sel_n  = 1'b0;
		we     = 1'b0;
		re     = 1'b0;
		waddr  = tail_q;
		raddr  = head_q;
		wdata  = ITEM_WIDTH'(req.data_in);
		unique case (req.func)
			rfo_pkg::OP_ENQ: begin
				we     = accept;
				tail_n = wrap_next(tail_q);
				if (full_cur) begin
					head_n = wrap_next(head_q);
				end
			end
			rfo_pkg::OP_DEQ: begin
				if (empty_cur) begin
					ok_n = 1'b0;
				end else begin
					sel_n  = 1'b1;
					re     = accept;
					head_n = wrap_next(head_q);
				end
			end
			rfo_pkg::OP_PEEK: begin
				raddr = IDX_W'(peek_idx);
				if (peek_ok) begin
					sel_n = 1'b1;
					re    = accept;
				end else begin
					ok_n = 1'b0;
				end
			end
			rfo_pkg::OP_CLR: begin
				head_n = tail_q;
			end
			default: begin
				ok_n = 1'b0;
			end
		endcase
	end

	// occupancy after the operation
	assign diff    = (IDX_W+1)'(tail_n) + ((tail_n < head_n) ? (IDX_W+1)'(SLOTS) : '0)
		- (IDX_W+1)'(head_n);
	assign cnt_ext = CNT_W'(diff[IDX_W-1:0]);

	assign adv_s1    = v_s1 & (~ov_q | rsp.ready);
	assign req.ready = init_done & (~v_s1 | adv_s1);
	assign accept    = req.valid & req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			v_s1   <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (accept) begin
				head_q <= head_n;
				tail_q <= tail_n;
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// transaction status, memory read data lands alongside
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1    <= ok_n;
			sel_s1   <= sel_n;
			count_s1 <= cnt_ext[rfo_pkg::COUNT_W-1:0];
			empty_s1 <= (head_n == tail_n);
			full_s1  <= (wrap_next(tail_n) == head_n);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp.ok       <= ok_s1;
			rsp.data_out <= sel_s1 ? rfo_pkg::DATA_W'(rdata) : '0;
			rsp.count    <= count_s1;
			rsp.is_empty <= empty_s1;
			rsp.is_full  <= full_s1;
		end
	end

	assign rsp.valid = ov_q;

endmodule

// ----- rtl/ring_fifo_overwrite_oldest_top.sv -----
// ----------------------------------------------------------------------------
// ring_fifo_overwrite_oldest_top
// circular fifo that overwrites its oldest item when full
// ----------------------------------------------------------------------------
// A ring of SLOTS entries holding up to SLOTS-1 items. Each request transaction
// gives one response transaction: enqueue, dequeue, peek at head plus offset, or
// clear. After reset the item memory is swept to zero, slot by slot, during
// which no request is taken. A response is registered in the status stage,
// where the read data lands, then in the output register; a new request is
// taken every cycle while responses are taken, so the sustained rate is one
// transaction per cycle and the block stalls only when its output is held.
module ring_fifo_overwrite_oldest_top #(
	parameter int SLOTS      = rfo_pkg::SLOTS_DEF,
	parameter int ITEM_WIDTH = rfo_pkg::ITEM_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rfo_req_if.sink   req,
	rfo_rsp_if.source rsp
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic                  we, re, init_done;
	logic [IDX_W-1:0]      waddr, raddr;
	logic [ITEM_WIDTH-1:0] wdata, rdata;

	rfo_ctrl #(
		.SLOTS      (SLOTS),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata),
		.init_done (init_done)
	);

	rfo_store #(
		.SLOTS      (SLOTS),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata),
		.init_done (init_done)
	);

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking testbench of the overwrite-oldest ring fifo
// ----------------------------------------------------------------------------
// Requests are driven on the request channel and each accepted request is run
// through a cycle-free model of the ring, whose predicted response is queued.
// A monitor compares every response transaction field by field with the oldest
// prediction. Directed tests cover the empty and stale reads, the offset
// limits, filling and overwriting, and clear; random phases then mix all
// operations under varying sender idling and receiver stalling, including a
// long receiver hold-off that backs the block up and a drain pause.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = rfo_pkg::SLOTS_DEF;
	localparam int HOLD_CYCLES  = 60;
	localparam int TAIL_CYCLES  = 10;
	localparam int WDOG_LIMIT   = 2000;

	typedef struct packed {
		logic            ok;
		rfo_pkg::data_t  data_out;
		rfo_pkg::count_t count;
		logic            is_empty;
		logic            is_full;
	} fifo_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	rfo_req_if req_if ();
	rfo_rsp_if rsp_if ();

	ring_fifo_overwrite_oldest_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #1 clk = ~clk;

	// model state of the ring
	rfo_pkg::data_t ring_mem [SLOTS];
	int             head_ptr;
	int             tail_ptr;
	fifo_rsp_t      rsp_expected [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int err_cnt       = 0;
	int idle_cycles   = 0;

	logic hold_tog  = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	function automatic fifo_rsp_t predict_fifo(input rfo_pkg::func_t f,
			input rfo_pkg::data_t d, input rfo_pkg::offset_t o);
		fifo_rsp_t r;
		r.ok       = 1'b1;
		r.data_out = '0;
		case (f)
			rfo_pkg::OP_ENQ: begin
				ring_mem[tail_ptr] = d;
				if ((tail_ptr + 1) % SLOTS == head_ptr)
					head_ptr = (head_ptr + 1) % SLOTS;
				tail_ptr = (tail_ptr + 1) % SLOTS;
			end
			rfo_pkg::OP_DEQ: begin
				if (head_ptr == tail_ptr) begin
					r.ok = 1'b0;
				end else begin
					r.data_out = ring_mem[head_ptr];
					head_ptr   = (head_ptr + 1) % SLOTS;
				end
			end
			rfo_pkg::OP_PEEK: begin
				if (int'(o) > SLOTS)
					r.ok = 1'b0;
				else
					r.data_out = ring_mem[(head_ptr + int'(o)) % SLOTS];
			end
			default: begin
				head_ptr = tail_ptr;
			end
		endcase
		r.count    = rfo_pkg::count_t'((tail_ptr + SLOTS - head_ptr) % SLOTS);
		r.is_empty = (head_ptr == tail_ptr);
		r.is_full  = ((tail_ptr + 1) % SLOTS == head_ptr);
		return r;
	endfunction

	// one request transaction, with random idle cycles ahead of it
	task automatic send_req(input rfo_pkg::func_t f, input rfo_pkg::data_t d,
			input rfo_pkg::offset_t o);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.func    <= f;
		req_if.data_in <= d;
		req_if.offset  <= o;
		do
			@(posedge clk);
		while (!req_if.ready);
		rsp_expected.push_back(predict_fifo(f, d, o));
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (rsp_expected.size() != 0);
	endtask

	task automatic send_random(input int n);
		int               sel;
		int               burst;
		rfo_pkg::func_t   f;
		rfo_pkg::offset_t o;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0) begin
				burst = $urandom_range(20, 8);
				for (int k = 0; k < burst; k++)
					send_req(rfo_pkg::OP_ENQ, rfo_pkg::data_t'($urandom),
						rfo_pkg::offset_t'($urandom));
				i += burst - 1;
			end else begin
				sel = $urandom_range(99);
				if (sel < 42)
					f = rfo_pkg::OP_ENQ;
				else if (sel < 72)
					f = rfo_pkg::OP_DEQ;
				else if (sel < 93)
					f = rfo_pkg::OP_PEEK;
				else
					f = rfo_pkg::OP_CLR;
				if ($urandom_range(7) == 0)
					o = rfo_pkg::offset_t'($urandom_range(31, SLOTS + 1));
				else
					o = rfo_pkg::offset_t'($urandom_range(SLOTS));
				send_req(f, rfo_pkg::data_t'($urandom), o);
			end
		end
	endtask

	task automatic test_empty_reads();
		send_req(rfo_pkg::OP_PEEK, '0, rfo_pkg::offset_t'(0));
		send_req(rfo_pkg::OP_PEEK, '1, rfo_pkg::offset_t'(SLOTS - 1));
		send_req(rfo_pkg::OP_PEEK, '0, rfo_pkg::offset_t'(SLOTS));
		send_req(rfo_pkg::OP_PEEK, '0, rfo_pkg::offset_t'(SLOTS + 1));
		send_req(rfo_pkg::OP_PEEK, '1, '1);
		send_req(rfo_pkg::OP_DEQ, '1, '1);
		send_req(rfo_pkg::OP_CLR, '1, '0);
	endtask

	task automatic test_fill_overwrite();
		send_req(rfo_pkg::OP_ENQ, '0, '0);
		send_req(rfo_pkg::OP_ENQ, '1, '1);
		for (int i = 2; i < SLOTS + 1; i++)
			send_req(rfo_pkg::OP_ENQ, rfo_pkg::data_t'($urandom),
				rfo_pkg::offset_t'($urandom));
		send_req(rfo_pkg::OP_PEEK, '0, rfo_pkg::offset_t'(SLOTS));
		send_req(rfo_pkg::OP_DEQ, '0, '0);
		send_req(rfo_pkg::OP_CLR, '0, '0);
		send_req(rfo_pkg::OP_PEEK, '0, rfo_pkg::offset_t'(3));
	endtask

	task automatic test_random_phases();
		send_idle_pct = 0;  stall_pct = 0;  send_random(100);
		send_idle_pct = 53; stall_pct = 0;  send_random(100);
		send_idle_pct = 0;  stall_pct = 53; send_random(100);
		send_idle_pct = 32; stall_pct = 32; send_random(100);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_tog     <= ~hold_tog;
		send_random(30);
		wait_drained();
		send_random(15);
	endtask

	// receiver: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen    <= hold_tog;
			hold_left    <= HOLD_CYCLES;
			rsp_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// response checker
	always @(posedge clk) begin
		fifo_rsp_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (rsp_expected.size() == 0) begin
				$error("unexpected response transaction");
				err_cnt++;
			end else begin
				e = rsp_expected.pop_front();
				if (rsp_if.ok !== e.ok) begin
					$error("ok: expected %0h, actual %0h", e.ok, rsp_if.ok);
					err_cnt++;
				end
				if (rsp_if.data_out !== e.data_out) begin
					$error("data_out: expected %0h, actual %0h", e.data_out, rsp_if.data_out);
					err_cnt++;
				end
				if (rsp_if.count !== e.count) begin
					$error("count: expected %0h, actual %0h", e.count, rsp_if.count);
					err_cnt++;
				end
				if (rsp_if.is_empty !== e.is_empty) begin
					$error("is_empty: expected %0h, actual %0h", e.is_empty, rsp_if.is_empty);
					err_cnt++;
				end
				if (rsp_if.is_full !== e.is_full) begin
					$error("is_full: expected %0h, actual %0h", e.is_full, rsp_if.is_full);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n && !(req_if.valid && req_if.ready) && !(rsp_if.valid && rsp_if.ready))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("** ring_fifo_overwrite_oldest_top: FAILED **");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SLOTS; i++)
			ring_mem[i] = '0;
		head_ptr       = 0;
		tail_ptr       = 0;
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.func    = rfo_pkg::OP_ENQ;
		req_if.data_in = '0;
		req_if.offset  = '0;
		rsp_if.ready   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_reads();
		test_fill_overwrite();
		test_random_phases();
		test_backpressure();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (rsp_expected.size() != 0) begin
			$error("responses missing: %0d", rsp_expected.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("** ring_fifo_overwrite_oldest_top: PASSED **");
		else
			$display("** ring_fifo_overwrite_oldest_top: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/rfo_pkg.sv
rtl/rfo_req_if.sv
rtl/rfo_rsp_if.sv
rtl/rfo_store.sv
rtl/rfo_ctrl.sv
rtl/ring_fifo_overwrite_oldest_top.sv
verif/tb.sv
